@@ sv/sbt_pkg.sv @@
// ----------------------------------------------------------------------------
// sbt_pkg: shared types and codes for the sorted breakpoint table
// Holds the beat payload structs, the table entry layout, result codes and
// the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbt_pkg;

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_FAULT   = 2'd3;

  // Register indexes of the configuration port (byte address bit 2).
  localparam logic REG_ARM_TRAP   = 1'b0;
  localparam logic REG_THUMB_TRAP = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] address;
    logic        thumb;
    logic        persist;
    logic [31:0] original_word;
    logic        access_fault;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] saved_word;
    logic        write_enable;
    logic [31:0] write_address;
    logic [31:0] write_data;
    logic        write_halfword;
  } out_item_t;

  typedef struct packed {
    logic [31:0] address;
    logic [31:0] saved_word;
    logic        is_halfword;
    logic        persistent;
  } entry_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_INSERT,
    ACT_DELETE
  } action_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_SCMP,
    S_INS_CHK,
    S_INS_MV,
    S_DEL_CHK,
    S_DEL_MV,
    S_DONE
  } sbt_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic srch_rd;
    logic idx_inc;
    logic decide;
    logic decide_cmp;
    logic ins_init;
    logic ins_rd;
    logic ins_wr;
    logic ins_new;
    logic del_init;
    logic del_rd;
    logic del_wr;
    logic finish;
  } sbt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic    srch_end;
    logic    srch_hit;
    action_t act;
    logic    ins_at_slot;
    logic    del_end;
  } sbt_stat_t;

endpackage

@@ sv/sbt_regs.sv @@
// ----------------------------------------------------------------------------
// sbt_regs: configuration registers
// Holds the word and halfword trap instructions behind the APB-style port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbt_regs
  import sbt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] arm_trap,
  output logic [15:0] thumb_trap
);

  logic [31:0] arm_trap_r;
  logic [15:0] thumb_trap_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_trap_r   <= '0;
      thumb_trap_r <= '0;
    end else if (wr_en) begin
      if (paddr[2] == REG_ARM_TRAP) begin
        arm_trap_r <= pwdata;
      end else begin
        thumb_trap_r <= pwdata[15:0];
      end
    end
  end

  assign prdata     = (paddr[2] == REG_THUMB_TRAP) ? {16'b0, thumb_trap_r} : arm_trap_r;
  assign arm_trap   = arm_trap_r;
  assign thumb_trap = thumb_trap_r;

endmodule

@@ sv/sbt_dp.sv @@
// ----------------------------------------------------------------------------
// sbt_dp: breakpoint table datapath
// Entry memory, scan index, request capture, result decision and count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbt_dp
  import sbt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    in_data,
  input  logic [31:0] arm_trap,
  input  logic [15:0] thumb_trap,
  input  sbt_cmd_t    cmd,
  output sbt_stat_t   stat,
  output out_item_t   out_data
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  entry_t          mem [TABLE_DEPTH];
  entry_t          rd_q;
  logic            rd_en;
  logic [CW-1:0]   rd_idx;
  logic            wr_en;
  entry_t          wr_ent;

  in_item_t        req_r;
  logic [31:0]     key_r;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   slot_r;
  logic [CW-1:0]   count_r;
  action_t         act_r;
  out_item_t       res_r;

  logic            found_c;
  logic            invalid_c;
  action_t         act_c;
  out_item_t       res_c;
  logic [CW-1:0]   idx_dec;
  logic [CW-1:0]   idx_inc;
  logic [CW:0]     idx_p1_wide;

  assign idx_dec     = idx_r - 1'b1;
  assign idx_inc     = idx_r + 1'b1;
  assign idx_p1_wide = {1'b0, idx_r} + 1'b1;

  // Memory ports: one registered read, one write.
  always_comb begin
    rd_en  = cmd.srch_rd || cmd.ins_rd || cmd.del_rd;
    rd_idx = idx_r;
    if (cmd.ins_rd) begin
      rd_idx = idx_dec;
    end else if (cmd.del_rd) begin
      rd_idx = idx_inc;
    end
    wr_en  = cmd.ins_wr || cmd.del_wr || cmd.ins_new;
    wr_ent = rd_q;
    if (cmd.ins_new) begin
      wr_ent.address     = key_r;
      wr_ent.saved_word  = req_r.thumb ? {16'b0, req_r.original_word[15:0]}
                                       : req_r.original_word;
      wr_ent.is_halfword = req_r.thumb;
      wr_ent.persistent  = req_r.persist;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx_r[AW-1:0]] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_idx[AW-1:0]];
    end
  end

  // Decision once the slot is known.
  always_comb begin
    found_c   = cmd.decide_cmp && (rd_q.address == key_r);
    invalid_c = (req_r.mode == MODE_ADD) && !req_r.thumb && (req_r.address[1:0] != 2'b00);
    act_c     = ACT_NONE;
    res_c     = '0;
    res_c.status = STAT_INVALID;
    case (req_r.mode)
      MODE_LOOKUP: begin
        if (found_c) begin
          res_c.status     = STAT_OK;
          res_c.saved_word = rd_q.saved_word;
        end
      end
      MODE_ADD: begin
        if (invalid_c) begin
          res_c.status = STAT_INVALID;
        end else if (found_c) begin
          res_c.status = STAT_OK;
        end else if (count_r == DEPTH_C) begin
          res_c.status = STAT_FULL;
        end else if (req_r.access_fault) begin
          res_c.status = STAT_FAULT;
        end else begin
          act_c                = ACT_INSERT;
          res_c.status         = STAT_OK;
          res_c.write_enable   = 1'b1;
          res_c.write_address  = key_r;
          res_c.write_data     = req_r.thumb ? {16'b0, thumb_trap} : arm_trap;
          res_c.write_halfword = req_r.thumb;
        end
      end
      MODE_REMOVE: begin
        if (!found_c) begin
          res_c.status = STAT_INVALID;
        end else if (req_r.access_fault) begin
          res_c.status = STAT_FAULT;
        end else begin
          act_c                = ACT_DELETE;
          res_c.status         = STAT_OK;
          res_c.write_enable   = 1'b1;
          res_c.write_address  = rd_q.address;
          res_c.write_data     = rd_q.is_halfword ? {16'b0, rd_q.saved_word[15:0]}
                                                  : rd_q.saved_word;
          res_c.write_halfword = rd_q.is_halfword;
        end
      end
      default: begin
        res_c.status = STAT_INVALID;
      end
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc || cmd.del_wr) begin
      idx_nxt = idx_inc;
    end else if (cmd.ins_wr) begin
      idx_nxt = idx_dec;
    end else if (cmd.ins_init) begin
      idx_nxt = count_r;
    end else if (cmd.del_init) begin
      // The search stopped on the entry being deleted, so the index is the slot.
      idx_nxt = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load) begin
      req_r <= in_data;
      // Lookups match the address as given; add and remove drop bit 0.
      key_r <= (in_data.mode == MODE_LOOKUP) ? in_data.address
                                             : {in_data.address[31:1], 1'b0};
    end
    if (cmd.decide) begin
      slot_r <= idx_r;
      res_r  <= res_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      act_r   <= ACT_NONE;
    end else begin
      if (cmd.decide) begin
        act_r <= act_c;
      end
      if (cmd.finish) begin
        if (act_r == ACT_INSERT) begin
          count_r <= count_r + 1'b1;
        end else if (act_r == ACT_DELETE) begin
          count_r <= count_r - 1'b1;
        end
      end
    end
  end

  assign stat.srch_end    = (idx_r == count_r);
  assign stat.srch_hit    = (rd_q.address >= key_r);
  assign stat.act         = act_c;
  assign stat.ins_at_slot = (idx_r == slot_r);
  assign stat.del_end     = (idx_p1_wide >= {1'b0, count_r});
  assign out_data         = res_r;

endmodule

@@ sv/sbt_ctrl.sv @@
// ----------------------------------------------------------------------------
// sbt_ctrl: breakpoint table controller
// Sequences the linear search, the decision and the shift of entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbt_ctrl
  import sbt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  sbt_stat_t stat,
  output sbt_cmd_t  cmd,
  output logic      busy,
  output logic      out_valid
);

  sbt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (stat.srch_end) begin
          if (stat.act == ACT_INSERT) begin
            state_nxt = S_INS_CHK;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        if (!stat.srch_hit) begin
          state_nxt = S_SRCH;
        end else if (stat.act == ACT_INSERT) begin
          state_nxt = S_INS_CHK;
        end else if (stat.act == ACT_DELETE) begin
          state_nxt = S_DEL_CHK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_INS_CHK: state_nxt = stat.ins_at_slot ? S_DONE : S_INS_MV;
      S_INS_MV:  state_nxt = S_INS_CHK;
      S_DEL_CHK: state_nxt = stat.del_end ? S_DONE : S_DEL_MV;
      S_DEL_MV:  state_nxt = S_DEL_CHK;
      S_DONE:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_SRCH: begin
        if (stat.srch_end) begin
          cmd.decide   = 1'b1;
          cmd.ins_init = (stat.act == ACT_INSERT);
        end else begin
          cmd.srch_rd = 1'b1;
        end
      end
      S_SCMP: begin
        if (stat.srch_hit) begin
          cmd.decide     = 1'b1;
          cmd.decide_cmp = 1'b1;
          cmd.ins_init   = (stat.act == ACT_INSERT);
          cmd.del_init   = (stat.act == ACT_DELETE);
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_INS_CHK: begin
        if (stat.ins_at_slot) begin
          cmd.ins_new = 1'b1;
        end else begin
          cmd.ins_rd = 1'b1;
        end
      end
      S_INS_MV:  cmd.ins_wr = 1'b1;
      S_DEL_CHK: cmd.del_rd = !stat.del_end;
      S_DEL_MV:  cmd.del_wr = 1'b1;
      S_DONE: begin
        cmd.finish = 1'b1;
        out_valid  = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

@@ sv/sorted_breakpoint_table.sv @@
// ----------------------------------------------------------------------------
// sorted_breakpoint_table: software breakpoint table kept sorted by address
// Handles one request at a time; the next start is taken the cycle after
// the result strobe.
// Synchronous active-low reset empties the table and clears both trap words.
// The result is shown for one cycle only; the receiver cannot stall it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_breakpoint_table
  import sbt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel: a beat is taken when start is high and busy is low.
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  // Result channel: one beat per request, valid for a single cycle.
  output logic        out_valid,
  output out_item_t   out_data,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // The table is one memory with a registered read port. A request walks it
  // from entry zero, one read and one compare per entry, until the first
  // entry whose address is not below the key or the end of the table. The
  // datapath then decides the result. An add that succeeds moves the tail of
  // the table up by one entry (read then write per entry) and writes the new
  // entry into the gap; a remove moves the tail down over the deleted entry.
  // The entry count only changes in the final cycle, with the result strobe.

  logic [31:0] arm_trap;
  logic [15:0] thumb_trap;
  sbt_cmd_t    cmd;
  sbt_stat_t   stat;

  sbt_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .arm_trap   (arm_trap),
    .thumb_trap (thumb_trap)
  );

  sbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  sbt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .arm_trap   (arm_trap),
    .thumb_trap (thumb_trap),
    .cmd        (cmd),
    .stat       (stat),
    .out_data   (out_data)
  );

endmodule

@@ verif/sorted_breakpoint_table_test.sv @@
// ----------------------------------------------------------------------------
// sorted_breakpoint_table_test: self-checking bench for the breakpoint table
// Drives lookup, add and remove requests through the start/busy channel,
// predicts every result beat from a behavioral copy of the sorted table and
// compares it field by field. Trap words are set over the APB port between
// phases and read back. A directed pass covers the corner cases, then random
// phases fill, drain and churn the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_breakpoint_table_test;
  import sbt_pkg::*;

  localparam int DEPTH = 16;

  // The package names only the three valid modes; the fourth code must be
  // answered as invalid and leave the table alone.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Upper bound on request latency with a full table, plus some margin.
  localparam int DRAIN_CYCLES = 80;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_data;
  logic        out_valid;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sorted_breakpoint_table #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // --------------------------------------------------------------------------
  // Shadow copy of the table and the trap words. It is advanced at the clock
  // edge that accepts each request, so it always matches the order in which
  // the block sees its work.
  // --------------------------------------------------------------------------
  entry_t      bp_table [DEPTH];
  int          bp_count;
  logic [31:0] trap_arm;
  logic [15:0] trap_thumb;

  // Results still owed by the block, oldest first.
  out_item_t   pending_responses[$];
  int          mismatch_count;

  // Number of upcoming requests that are sent back to back with no gap.
  int          burst_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #7_000_000;
    $display("sorted_breakpoint_table_test: FAIL");
    $finish;
  end

  // First entry whose address is not below a, or the entry count.
  function automatic int slot_of(input logic [31:0] a);
    for (int i = 0; i < bp_count; i++) begin
      if (bp_table[i].address >= a) begin
        return i;
      end
    end
    return bp_count;
  endfunction

  function automatic bit holds_at(input int slot, input logic [31:0] a);
    return (slot < bp_count) && (bp_table[slot].address == a);
  endfunction

  // Applies one request to the shadow table and returns the beat the block
  // must answer with.
  function automatic out_item_t apply_request(input in_item_t req);
    out_item_t   rsp;
    logic [31:0] addr;
    int          slot;
    rsp        = '0;
    rsp.status = STAT_INVALID;
    // Add and remove ignore bit 0; lookup uses the address exactly as given.
    addr       = {req.address[31:1], 1'b0};
    case (req.mode)
      MODE_LOOKUP: begin
        slot = slot_of(req.address);
        if (holds_at(slot, req.address)) begin
          rsp.status     = STAT_OK;
          rsp.saved_word = bp_table[slot].saved_word;
        end
      end
      MODE_ADD: begin
        // A word breakpoint must sit on a four-byte boundary.
        if (!req.thumb && req.address[1:0] != 2'b00) begin
          rsp.status = STAT_INVALID;
        end else begin
          slot = slot_of(addr);
          // The existing-entry check wins over both the full and fault cases.
          if (holds_at(slot, addr)) begin
            rsp.status = STAT_OK;
          end else if (bp_count >= DEPTH) begin
            rsp.status = STAT_FULL;
          end else if (req.access_fault) begin
            rsp.status = STAT_FAULT;
          end else begin
            for (int i = bp_count; i > slot; i--) begin
              bp_table[i] = bp_table[i - 1];
            end
            bp_table[slot].address     = addr;
            bp_table[slot].saved_word  = req.thumb ? {16'h0000, req.original_word[15:0]}
                                                   : req.original_word;
            bp_table[slot].is_halfword = req.thumb;
            bp_table[slot].persistent  = req.persist;
            bp_count++;
            rsp.status         = STAT_OK;
            rsp.write_enable   = 1'b1;
            rsp.write_address  = addr;
            rsp.write_data     = req.thumb ? {16'h0000, trap_thumb} : trap_arm;
            rsp.write_halfword = req.thumb;
          end
        end
      end
      MODE_REMOVE: begin
        slot = slot_of(addr);
        if (!holds_at(slot, addr)) begin
          rsp.status = STAT_INVALID;
        end else if (req.access_fault) begin
          // The restore failed, so the breakpoint stays in the table.
          rsp.status = STAT_FAULT;
        end else begin
          rsp.status         = STAT_OK;
          rsp.write_enable   = 1'b1;
          rsp.write_address  = bp_table[slot].address;
          rsp.write_data     = bp_table[slot].is_halfword
                               ? {16'h0000, bp_table[slot].saved_word[15:0]}
                               : bp_table[slot].saved_word;
          rsp.write_halfword = bp_table[slot].is_halfword;
          for (int i = slot; i + 1 < bp_count; i++) begin
            bp_table[i] = bp_table[i + 1];
          end
          bp_count--;
        end
      end
      default: begin
        rsp.status = STAT_INVALID;
      end
    endcase
    return rsp;
  endfunction

  function automatic in_item_t bp_request(input logic [1:0] mode, input logic [31:0] address,
                                          input logic thumb, input logic persist,
                                          input logic [31:0] original_word,
                                          input logic access_fault);
    in_item_t req;
    req.mode          = mode;
    req.address       = address;
    req.thumb         = thumb;
    req.persist       = persist;
    req.original_word = original_word;
    req.access_fault  = access_fault;
    return req;
  endfunction

  // Random request. Half of the addresses are taken from live entries so
  // that lookups and removes hit; the rest come from two narrow windows, one
  // at the top of the address space, or from anywhere.
  function automatic in_item_t rand_request(input int add_w, input int rem_w,
                                            input int look_w);
    in_item_t req;
    int       roll;
    int       pick;
    roll = $urandom_range(99);
    pick = $urandom_range(9);
    if (roll < add_w) begin
      req.mode = MODE_ADD;
    end else if (roll < add_w + rem_w) begin
      req.mode = MODE_REMOVE;
    end else if (roll < add_w + rem_w + look_w) begin
      req.mode = MODE_LOOKUP;
    end else begin
      req.mode = MODE_UNUSED;
    end
    req.thumb         = 1'($urandom_range(1));
    req.persist       = 1'($urandom_range(1));
    req.original_word = $urandom();
    req.access_fault  = ($urandom_range(9) == 0);
    if (pick < 5 && bp_count > 0) begin
      req.address = bp_table[$urandom_range(bp_count - 1)].address;
      if ($urandom_range(3) == 0) begin
        req.address[0] = 1'b1;
      end
    end else if (pick < 8) begin
      req.address = 32'h0800_0000 + ($urandom_range(47) << 1);
    end else if (pick == 8) begin
      req.address = 32'hFFFF_FF80 + ($urandom_range(63) << 1);
    end else begin
      req.address = $urandom();
    end
    // Most word adds are aligned so that they get past the alignment check.
    if (req.mode == MODE_ADD && !req.thumb && $urandom_range(99) < 85) begin
      req.address[1:0] = 2'b00;
    end
    return req;
  endfunction

  // Sends one request beat. Entered and left at a falling edge. The gap is
  // drawn per request, except during a burst, where beats follow back to
  // back. start stays high on return so a following beat needs no toggle.
  task automatic send_request(input in_item_t req);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(18);
      if ($urandom_range(15) == 0) begin
        burst_left = $urandom_range(20);
      end
    end
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data = req;
    start   = 1'b1;
    do begin
      @(posedge clk);
    end while (busy);
    pending_responses.push_back(apply_request(req));
    @(negedge clk);
  endtask

  // Lowers start and waits until every owed result has come back.
  task automatic wait_quiet();
    start = 1'b0;
    while (pending_responses.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = addr;
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Writes both trap words and reads them back. Only called while idle.
  task automatic set_trap_words(input logic [31:0] arm, input logic [15:0] thumb);
    logic [31:0] rdata;
    wait_quiet();
    apb_access(1'b1, {REG_ARM_TRAP, 2'b00}, arm, rdata);
    trap_arm = arm;
    apb_access(1'b1, {REG_THUMB_TRAP, 2'b00}, {16'h0000, thumb}, rdata);
    trap_thumb = thumb;
    apb_access(1'b0, {REG_ARM_TRAP, 2'b00}, '0, rdata);
    if (rdata !== trap_arm) begin
      $error("arm_trap_word: expected %08h, got %08h", trap_arm, rdata);
      mismatch_count++;
    end
    apb_access(1'b0, {REG_THUMB_TRAP, 2'b00}, '0, rdata);
    if (rdata !== {16'h0000, trap_thumb}) begin
      $error("thumb_trap_word: expected %08h, got %08h", {16'h0000, trap_thumb}, rdata);
      mismatch_count++;
    end
  endtask

  task automatic check_response(input out_item_t exp_rsp, input out_item_t got);
    if (got.status !== exp_rsp.status) begin
      $error("status: expected %0d, got %0d", exp_rsp.status, got.status);
      mismatch_count++;
    end
    if (got.saved_word !== exp_rsp.saved_word) begin
      $error("saved_word: expected %08h, got %08h", exp_rsp.saved_word, got.saved_word);
      mismatch_count++;
    end
    if (got.write_enable !== exp_rsp.write_enable) begin
      $error("write_enable: expected %0d, got %0d", exp_rsp.write_enable, got.write_enable);
      mismatch_count++;
    end
    if (got.write_address !== exp_rsp.write_address) begin
      $error("write_address: expected %08h, got %08h", exp_rsp.write_address,
             got.write_address);
      mismatch_count++;
    end
    if (got.write_data !== exp_rsp.write_data) begin
      $error("write_data: expected %08h, got %08h", exp_rsp.write_data, got.write_data);
      mismatch_count++;
    end
    if (got.write_halfword !== exp_rsp.write_halfword) begin
      $error("write_halfword: expected %0d, got %0d", exp_rsp.write_halfword,
             got.write_halfword);
      mismatch_count++;
    end
  endtask

  // Result beats last one cycle and cannot be held off, so every strobe seen
  // at a rising edge is taken and matched against the oldest prediction.
  always @(posedge clk) begin : response_monitor
    out_item_t exp_rsp;
    if (rst_n && out_valid) begin
      if (pending_responses.size() == 0) begin
        $error("out_valid: result beat with no request outstanding");
        mismatch_count++;
      end else begin
        exp_rsp = pending_responses.pop_front();
        check_response(exp_rsp, out_data);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed corner cases. The first adds run with the trap words still at
  // their reset value of zero.
  // --------------------------------------------------------------------------
  task automatic test_directed_ops();
    send_request(bp_request(MODE_LOOKUP, 32'h0000_0000, 1'b0, 1'b0, '0, 1'b0));
    send_request(bp_request(MODE_REMOVE, 32'h0000_0001, 1'b1, 1'b1, '1, 1'b0));
    send_request(bp_request(MODE_UNUSED, $urandom(), 1'b1, 1'b1, $urandom(), 1'b1));
    // Word adds that are not four-byte aligned are refused.
    send_request(bp_request(MODE_ADD, 32'h0000_1002, 1'b0, 1'b0, $urandom(), 1'b0));
    send_request(bp_request(MODE_ADD, 32'h0000_1001, 1'b0, 1'b1, $urandom(), 1'b0));
    // A faulting memory access undoes the add.
    send_request(bp_request(MODE_ADD, 32'h0000_1000, 1'b0, 1'b0, $urandom(), 1'b1));
    send_request(bp_request(MODE_ADD, 32'hFFFF_FFFC, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0));
    set_trap_words(32'hFFFF_FFFF, 16'hFFFF);
    send_request(bp_request(MODE_ADD, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0));
    // Halfword add at an odd address lands on the even one, low half saved.
    send_request(bp_request(MODE_ADD, 32'h0000_2001, 1'b1, 1'b1, 32'hABCD_1234, 1'b0));
    // Re-adding an existing entry succeeds silently, even with a fault.
    send_request(bp_request(MODE_ADD, 32'h0000_2000, 1'b1, 1'b0, 32'h5555_5555, 1'b1));
    send_request(bp_request(MODE_ADD, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0));
    // Lookup does not clear bit 0, so the odd address misses.
    send_request(bp_request(MODE_LOOKUP, 32'h0000_2001, 1'b0, 1'b0, '0, 1'b0));
    send_request(bp_request(MODE_LOOKUP, 32'h0000_2000, 1'b1, 1'b1, '1, 1'b1));
    send_request(bp_request(MODE_LOOKUP, 32'hFFFF_FFFC, 1'b0, 1'b0, '0, 1'b0));
    // Remove with a fault keeps the entry; the retry restores the halfword.
    send_request(bp_request(MODE_REMOVE, 32'h0000_2001, 1'b0, 1'b0, '0, 1'b1));
    send_request(bp_request(MODE_REMOVE, 32'h0000_2001, 1'b0, 1'b0, '0, 1'b0));
    send_request(bp_request(MODE_REMOVE, 32'h0000_2000, 1'b0, 1'b0, '0, 1'b0));
    send_request(bp_request(MODE_REMOVE, 32'hFFFF_FFFF, 1'b0, 1'b0, '1, 1'b0));
    send_request(bp_request(MODE_ADD, 32'h8000_0000, 1'b0, 1'b0, 32'h5555_AAAA, 1'b0));
    send_request(bp_request(MODE_LOOKUP, 32'h8000_0000, 1'b0, 1'b0, '0, 1'b0));
    // A halfword add on top of a word entry is treated as already present.
    send_request(bp_request(MODE_ADD, 32'h8000_0001, 1'b1, 1'b1, $urandom(), 1'b0));
    send_request(bp_request(MODE_REMOVE, 32'h0000_0000, 1'b1, 1'b1, '1, 1'b0));
  endtask

  // Fills the table, probes adds of new and existing addresses against a full
  // table, reads every entry back and then empties the table in random order.
  task automatic test_table_full();
    logic [31:0] fresh;
    logic [31:0] taken;
    set_trap_words($urandom(), 16'($urandom()));
    while (bp_count < DEPTH) begin
      send_request(bp_request(MODE_ADD, $urandom() & 32'hFFFF_FFFC, 1'b0,
                              1'($urandom_range(1)), $urandom(), 1'b0));
    end
    fresh = bp_table[0].address ^ 32'h0000_0004;
    if (holds_at(slot_of(fresh), fresh)) begin
      fresh = bp_table[0].address ^ 32'h0000_0008;
    end
    taken = bp_table[DEPTH - 1].address;
    send_request(bp_request(MODE_ADD, fresh, 1'b0, 1'b0, $urandom(), 1'b0));
    send_request(bp_request(MODE_ADD, fresh, 1'b0, 1'b0, $urandom(), 1'b1));
    send_request(bp_request(MODE_ADD, fresh | 32'h2, 1'b1, 1'b1, $urandom(), 1'b0));
    send_request(bp_request(MODE_ADD, taken, 1'b0, 1'b1, $urandom(), 1'b0));
    send_request(bp_request(MODE_REMOVE, bp_table[0].address, 1'b0, 1'b0, '0, 1'b0));
    send_request(bp_request(MODE_ADD, fresh, 1'b1, 1'b1, $urandom(), 1'b0));
    for (int i = 0; i < DEPTH; i++) begin
      send_request(bp_request(MODE_LOOKUP, bp_table[i].address, 1'b0, 1'b0, '0, 1'b0));
    end
    while (bp_count > 0) begin
      send_request(bp_request(MODE_REMOVE, bp_table[$urandom_range(bp_count - 1)].address,
                              1'($urandom_range(1)), 1'($urandom_range(1)), $urandom(),
                              1'b0));
    end
  endtask

  // Random requests with the given mix of add, remove and lookup weights in
  // percent; the remainder uses the unused mode. With hold_off set the sender
  // stops every few beats until all results are back.
  task automatic run_random(input int count, input int add_w, input int rem_w,
                            input int look_w, input bit hold_off);
    for (int n = 0; n < count; n++) begin
      if (hold_off && (n % 8) == 7) begin
        wait_quiet();
      end
      send_request(rand_request(add_w, rem_w, look_w));
    end
  endtask

  task automatic test_random_mixed();
    set_trap_words(32'hFFFF_FFFF, 16'hFFFF);
    run_random(450, 40, 30, 25, 1'b0);
  endtask

  // Swings the table between full and nearly empty.
  task automatic test_random_fill_drain();
    set_trap_words($urandom(), 16'($urandom()));
    for (int r = 0; r < 3; r++) begin
      run_random(100, 70, 10, 15, 1'b0);
      run_random(100, 15, 60, 20, 1'b0);
    end
  endtask

  task automatic test_random_paced();
    set_trap_words(32'h0000_0000, 16'h0000);
    run_random(150, 40, 30, 25, 1'b1);
    set_trap_words(32'hE7F0_01F0, 16'hDE01);
    run_random(150, 40, 30, 25, 1'b1);
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_data        = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    bp_count       = 0;
    trap_arm       = '0;
    trap_thumb     = '0;
    mismatch_count = 0;
    burst_left     = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed_ops();
    test_table_full();
    test_random_mixed();
    test_random_fill_drain();
    test_random_paced();

    // Let the last result arrive, then watch for any stray beats.
    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_responses.size() == 0) begin
      $display("sorted_breakpoint_table_test: PASS");
    end else begin
      $display("sorted_breakpoint_table_test: FAIL");
    end
    $finish;
  end

endmodule
